/* rtl/sphere_texture_coordinate_mapper_core_defines.svh */
// Assertion macros used by the RTL of the sphere mapper core.
`ifndef SPHERE_TEXTURE_COORDINATE_MAPPER_CORE_DEFINES_SVH
`define SPHERE_TEXTURE_COORDINATE_MAPPER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

/* rtl/stcm_pkg.sv */
package stcm_pkg;

  // Fixed field widths
  localparam int COORD_BITS    = 10;
  localparam int FRAC_BITS_DEF = 14;
  localparam int RADIUS_W      = 9;
  localparam int TRIG_W        = 16;
  localparam int TRIG_SHIFT    = 14;
  localparam int TSIZE_W       = 11;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // Register reset values
  localparam int RADIUS_RST = 128;
  localparam int TRIG_ONE   = 16384;
  localparam int TSIZE_RST  = 256;

  // Angles in units of 2^-24 turn
  localparam int ANG_STEPS   = 24;
  localparam int ANG_W       = 26;
  localparam int ANG_ONE     = 1 << 24;
  localparam int ANG_HALF    = 1 << 23;
  localparam int ANG_QUARTER = 1 << 22;

  // Q0.16 texture coordinates, 1.0 included
  localparam int Q16_W     = 17;
  localparam int Q16_FRAC  = 16;
  localparam int Q16_ONE   = 1 << 16;
  localparam int Q16_ROUND = 128;
  localparam int Q16_SHIFT = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 3'd0,
    CFG_COS_SPIN = 3'd1,
    CFG_SIN_SPIN = 3'd2,
    CFG_COS_TILT = 3'd3,
    CFG_SIN_TILT = 3'd4,
    CFG_TEX_W    = 3'd5,
    CFG_TEX_H    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
  } pix_t;

  typedef struct packed {
    logic                  inside_res;
    logic [COORD_BITS-1:0] tex_x;
    logic [COORD_BITS-1:0] tex_y;
  } tex_t;

  // atan(2^-i) in 2^-24 turn
  function automatic logic signed [ANG_W-1:0] atan_turn(input int step);
    logic signed [ANG_W-1:0] val;
    case (step)
      0:  val = ANG_W'(2097152);
      1:  val = ANG_W'(1238021);
      2:  val = ANG_W'(654136);
      3:  val = ANG_W'(332050);
      4:  val = ANG_W'(166669);
      5:  val = ANG_W'(83416);
      6:  val = ANG_W'(41718);
      7:  val = ANG_W'(20860);
      8:  val = ANG_W'(10430);
      9:  val = ANG_W'(5215);
      10: val = ANG_W'(2608);
      11: val = ANG_W'(1304);
      12: val = ANG_W'(652);
      13: val = ANG_W'(326);
      14: val = ANG_W'(163);
      15: val = ANG_W'(81);
      16: val = ANG_W'(41);
      17: val = ANG_W'(20);
      18: val = ANG_W'(10);
      19: val = ANG_W'(5);
      20: val = ANG_W'(3);
      21: val = ANG_W'(1);
      22: val = ANG_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/stcm_isqrt.sv */
module stcm_isqrt #(
  parameter int OUT_W  = 23,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2*OUT_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [OUT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int RemW = 2*OUT_W + 1;

  logic [OUT_W:0]      vld_q;
  logic [RemW-1:0]     rem_q  [OUT_W];
  logic [RemW-1:0]     rem_d  [OUT_W];
  logic [OUT_W-1:0]    root_q [OUT_W+1];
  logic [OUT_W-1:0]    root_d [OUT_W];
  logic [SIDE_W-1:0]   side_q [OUT_W+1];

  // One result bit per stage, most significant first
  always_comb begin
    logic [RemW-1:0] trial;
    for (int k = 0; k < OUT_W; k++) begin
      trial = (RemW'(root_q[k]) << (OUT_W - k)) | (RemW'(1) << (2*(OUT_W-1-k)));
      if (rem_q[k] >= trial) begin
        rem_d[k]  = rem_q[k] - trial;
        root_d[k] = root_q[k] | (OUT_W'(1) << (OUT_W-1-k));
      end else begin
        rem_d[k]  = rem_q[k];
        root_d[k] = root_q[k];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[OUT_W-1:0], valid_i};
    end
  end

  // Advance stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {1'b0, rad_i};
      root_q[0] <= '0;
      side_q[0] <= side_i;
      for (int k = 0; k < OUT_W; k++) begin
        if (k < OUT_W-1) begin
          rem_q[k+1] <= rem_d[k];
        end
        root_q[k+1] <= root_d[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[OUT_W];
  assign root_o  = root_q[OUT_W];
  assign side_o  = side_q[OUT_W];

endmodule

/* rtl/stcm_cordic.sv */
module stcm_cordic #(
  parameter int IN_W   = 28,
  parameter int SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [IN_W-1:0]            y_i,
  input  logic signed [IN_W-1:0]            x_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [stcm_pkg::ANG_W-1:0] ang_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int N  = stcm_pkg::ANG_STEPS;
  localparam int XW = IN_W + 3;
  localparam int AW = stcm_pkg::ANG_W;
  localparam logic signed [AW-1:0] Quarter = AW'(stcm_pkg::ANG_QUARTER);
  localparam logic signed [AW-1:0] Half    = AW'(stcm_pkg::ANG_HALF);

  logic [N+1:0]            vld_q;
  logic signed [XW-1:0]    x_q [N+1];
  logic signed [XW-1:0]    y_q [N+1];
  logic signed [AW-1:0]    z_q [N+1];
  logic signed [XW-1:0]    x_d [N];
  logic signed [XW-1:0]    y_d [N];
  logic signed [AW-1:0]    z_d [N];
  logic                    xneg_q [N+1];
  logic                    yneg_q [N+1];
  logic [SIDE_W-1:0]       side_q [N+1];
  logic signed [AW-1:0]    ang_d;
  logic signed [AW-1:0]    ang_q;
  logic [SIDE_W-1:0]       side_out_q;

  // Vectoring rotations, one per stage
  always_comb begin
    for (int k = 0; k < N; k++) begin
      x_d[k] = x_q[k];
      y_d[k] = y_q[k];
      z_d[k] = z_q[k];
      if (y_q[k] > 0) begin
        x_d[k] = x_q[k] + (y_q[k] >>> k);
        y_d[k] = y_q[k] - (x_q[k] >>> k);
        z_d[k] = z_q[k] + stcm_pkg::atan_turn(k);
      end else if (y_q[k] < 0) begin
        x_d[k] = x_q[k] - (y_q[k] >>> k);
        y_d[k] = y_q[k] + (x_q[k] >>> k);
        z_d[k] = z_q[k] - stcm_pkg::atan_turn(k);
      end
    end
  end

  // Clamp to the first quadrant, then reflect by input signs
  always_comb begin
    ang_d = z_q[N];
    if (ang_d < 0) begin
      ang_d = '0;
    end else if (ang_d > Quarter) begin
      ang_d = Quarter;
    end
    if (xneg_q[N]) begin
      ang_d = Half - ang_d;
    end
    if (yneg_q[N]) begin
      ang_d = -ang_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x_i[IN_W-1] ? -XW'(x_i) : XW'(x_i);
      y_q[0]    <= y_i[IN_W-1] ? -XW'(y_i) : XW'(y_i);
      z_q[0]    <= '0;
      xneg_q[0] <= x_i[IN_W-1];
      yneg_q[0] <= y_i[IN_W-1];
      side_q[0] <= side_i;
      for (int k = 0; k < N; k++) begin
        x_q[k+1]    <= x_d[k];
        y_q[k+1]    <= y_d[k];
        z_q[k+1]    <= z_d[k];
        xneg_q[k+1] <= xneg_q[k];
        yneg_q[k+1] <= yneg_q[k];
        side_q[k+1] <= side_q[k];
      end
      ang_q      <= ang_d;
      side_out_q <= side_q[N];
    end
  end

  assign valid_o = vld_q[N+1];
  assign ang_o   = ang_q;
  assign side_o  = side_out_q;

endmodule

/* rtl/sphere_texture_coordinate_mapper_core.sv */
// Sphere texture coordinate mapper.
// Input channel: pix_i carries one screen pixel (pix_x, pix_y); it is taken
// at a clock edge with valid_i high and stall_o low. Output channel: res_o
// carries inside_res, tex_x and tex_y; it is taken with valid_o high and
// stall_i low. Pixels off the disc come out with inside_res low and zero
// texture coordinates.
// Registers are written over the cfg channel (cfg_index_i, cfg_data_i),
// always ready; write them only while no item is in flight.
// The delay through the core is set by the two bit-serial square root
// pipelines and the two 24-step angle pipelines.
// Throughput is one item per cycle while stall_o is low.
// When the output register holds an item and stall_i is high, the whole
// pipeline freezes and stall_o rises; nothing is dropped or repeated.
// Reset clears all valid bits and loads radius 128, unit cosines, zero
// sines and a 256 by 256 texture.
`include "sphere_texture_coordinate_mapper_core_defines.svh"

module sphere_texture_coordinate_mapper_core #(
  parameter int FRAC_BITS = stcm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  stcm_pkg::pix_t                      pix_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output stcm_pkg::tex_t                      res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stcm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [stcm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int C    = stcm_pkg::COORD_BITS;
  localparam int RB   = stcm_pkg::RADIUS_W;
  localparam int TW   = stcm_pkg::TRIG_W;
  localparam int SW   = stcm_pkg::TSIZE_W;
  localparam int AW   = stcm_pkg::ANG_W;
  localparam int QW   = stcm_pkg::Q16_W;
  localparam int LXW  = ((C > RB) ? C : RB) + 1;
  localparam int PLW  = RB + 1;
  localparam int OW   = RB + FRAC_BITS;
  localparam int RW   = OW + 5;
  localparam int M1W  = PLW + TW;
  localparam int M2W  = OW + 1 + TW;
  localparam int S1W  = OW + TW + 2;
  localparam int M6W  = RW + TW;
  localparam int S2W  = M6W + 1;
  localparam int PUW  = QW + SW;

  typedef struct packed {
    logic                  on_disc;
    logic signed [PLW-1:0] lx;
    logic signed [PLW-1:0] ly;
  } sq1_side_t;

  typedef struct packed {
    logic                 on_disc;
    logic signed [RW-1:0] ry;
  } ang1_side_t;

  typedef struct packed {
    logic                   on_disc;
    logic signed [AW-1:0]   u;
    logic signed [OW:0]     s;
  } sq2_side_t;

  typedef struct packed {
    logic                 on_disc;
    logic signed [AW-1:0] u;
  } ang2_side_t;

  // Configuration registers
  logic [RB-1:0]        radius_q;
  logic signed [TW-1:0] cos_spin_q, sin_spin_q, cos_tilt_q, sin_tilt_q;
  logic [SW-1:0]        tex_w_q, tex_h_q;
  logic [2*RB-1:0]      r_sq;

  // Pipeline control
  logic adv;
  logic v_a_q, v_b_q, v_d_q, v_e_q, v_f_q, v_g_q, v_h_q, v_i_q, v_k_q, v_l_q;
  logic out_valid_q;

  // Stage data
  logic signed [LXW-1:0]   lx_d, ly_d, lx_a_q, ly_a_q;
  logic signed [2*LXW-1:0] lsq_x_q, lsq_y_q;
  logic signed [PLW-1:0]   lx_b_q, ly_b_q;
  logic [2*LXW:0]          d2_c;
  logic [2*RB-1:0]         diff_c;
  logic [2*OW-1:0]         rad1_c;
  sq1_side_t               sq1_in, sq1_out;
  logic                    sq1_valid;
  logic [OW-1:0]           pz;

  logic signed [M1W-1:0]   m1_q, m3_q, m5_q, m7_q;
  logic signed [M2W-1:0]   m2_q, m4_q;
  logic signed [M6W-1:0]   m6_q, m8_q;
  logic signed [PLW-1:0]   ly_d_q, ly_e_q;
  logic                    in_d_q, in_e_q, in_f_q, in_g_q;
  logic signed [S1W-1:0]   tx_s, tz_s;
  logic signed [RW-1:0]    tx_e_q, tz_e_q, tx_f_q, tx_g_q;
  logic signed [S2W-1:0]   ry_s, rz_s;
  logic signed [RW-1:0]    ry_g_q, rz_g_q;

  ang1_side_t              ang1_in, ang1_out;
  logic                    ang1_valid;
  logic signed [AW-1:0]    theta;
  logic signed [AW-1:0]    u_c;
  logic signed [RW-1:0]    big_r, neg_ry, s_c;
  logic signed [AW-1:0]    u_h_q, u_i_q;
  logic signed [OW:0]      s_h_q, s_i_q;
  logic                    in_h_q, in_i_q;
  logic signed [2*OW+1:0]  sq_i_q;
  logic [2*OW-1:0]         rad2_c;
  sq2_side_t               sq2_in, sq2_out;
  logic                    sq2_valid;
  logic [OW-1:0]           qv;

  ang2_side_t              ang2_in, ang2_out;
  logic                    ang2_valid;
  logic signed [AW-1:0]    phi;
  logic signed [AW-1:0]    ur_c, vr_c;
  logic [QW-1:0]           qu_k_q, qv_k_q;
  logic                    in_k_q, in_l_q;
  logic [SW-1:0]           mw_c, mh_c;
  logic [PUW-1:0]          pu_l_q, pv_l_q;
  logic [SW:0]             tx_full, ty_full;
  stcm_pkg::tex_t          res_d, res_q;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RB'(stcm_pkg::RADIUS_RST);
      cos_spin_q <= TW'(stcm_pkg::TRIG_ONE);
      sin_spin_q <= '0;
      cos_tilt_q <= TW'(stcm_pkg::TRIG_ONE);
      sin_tilt_q <= '0;
      tex_w_q    <= SW'(stcm_pkg::TSIZE_RST);
      tex_h_q    <= SW'(stcm_pkg::TSIZE_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        stcm_pkg::CFG_RADIUS:   radius_q   <= cfg_data_i[RB-1:0];
        stcm_pkg::CFG_COS_SPIN: cos_spin_q <= cfg_data_i[TW-1:0];
        stcm_pkg::CFG_SIN_SPIN: sin_spin_q <= cfg_data_i[TW-1:0];
        stcm_pkg::CFG_COS_TILT: cos_tilt_q <= cfg_data_i[TW-1:0];
        stcm_pkg::CFG_SIN_TILT: sin_tilt_q <= cfg_data_i[TW-1:0];
        stcm_pkg::CFG_TEX_W:    tex_w_q    <= cfg_data_i[SW-1:0];
        stcm_pkg::CFG_TEX_H:    tex_h_q    <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  assign r_sq  = radius_q * radius_q;
  assign big_r = RW'({radius_q, {FRAC_BITS{1'b0}}});

  // Freeze the pipeline while the output item waits
  assign stall_o = out_valid_q && stall_i;
  assign adv     = !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q       <= 1'b0;
      v_b_q       <= 1'b0;
      v_d_q       <= 1'b0;
      v_e_q       <= 1'b0;
      v_f_q       <= 1'b0;
      v_g_q       <= 1'b0;
      v_h_q       <= 1'b0;
      v_i_q       <= 1'b0;
      v_k_q       <= 1'b0;
      v_l_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_a_q       <= valid_i;
      v_b_q       <= v_a_q;
      v_d_q       <= sq1_valid;
      v_e_q       <= v_d_q;
      v_f_q       <= v_e_q;
      v_g_q       <= v_f_q;
      v_h_q       <= ang1_valid;
      v_i_q       <= v_h_q;
      v_k_q       <= ang2_valid;
      v_l_q       <= v_k_q;
      out_valid_q <= v_l_q;
    end
  end

  // Offsets from the disc center
  assign lx_d = LXW'(pix_i.pix_x) - LXW'(radius_q);
  assign ly_d = LXW'(pix_i.pix_y) - LXW'(radius_q);

  // Disc test and sphere depth radicand
  always_comb begin
    d2_c   = (2*LXW+1)'($unsigned(lsq_x_q)) + (2*LXW+1)'($unsigned(lsq_y_q));
    diff_c = r_sq - d2_c[2*RB-1:0];
    rad1_c = {diff_c, {(2*FRAC_BITS){1'b0}}};
    sq1_in.on_disc = d2_c <= (2*LXW+1)'(r_sq);
    sq1_in.lx      = lx_b_q;
    sq1_in.ly      = ly_b_q;
  end

  // Spin about Y and tilt about X: sums of products
  always_comb begin
    tx_s = ((S1W'(m1_q) <<< FRAC_BITS) - S1W'(m2_q)) >>> stcm_pkg::TRIG_SHIFT;
    tz_s = ((S1W'(m3_q) <<< FRAC_BITS) + S1W'(m4_q)) >>> stcm_pkg::TRIG_SHIFT;
    ry_s = ((S2W'(m5_q) <<< FRAC_BITS) - S2W'(m6_q)) >>> stcm_pkg::TRIG_SHIFT;
    rz_s = ((S2W'(m7_q) <<< FRAC_BITS) + S2W'(m8_q)) >>> stcm_pkg::TRIG_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lx_a_q  <= lx_d;
      ly_a_q  <= ly_d;
      lsq_x_q <= lx_a_q * lx_a_q;
      lsq_y_q <= ly_a_q * ly_a_q;
      lx_b_q  <= lx_a_q[PLW-1:0];
      ly_b_q  <= ly_a_q[PLW-1:0];
      // spin products
      m1_q    <= sq1_out.lx * cos_spin_q;
      m2_q    <= $signed({1'b0, pz}) * sin_spin_q;
      m3_q    <= sq1_out.lx * sin_spin_q;
      m4_q    <= $signed({1'b0, pz}) * cos_spin_q;
      ly_d_q  <= sq1_out.ly;
      in_d_q  <= sq1_out.on_disc;
      tx_e_q  <= tx_s[RW-1:0];
      tz_e_q  <= tz_s[RW-1:0];
      ly_e_q  <= ly_d_q;
      in_e_q  <= in_d_q;
      // tilt products
      m5_q    <= ly_e_q * cos_tilt_q;
      m6_q    <= tz_e_q * sin_tilt_q;
      m7_q    <= ly_e_q * sin_tilt_q;
      m8_q    <= tz_e_q * cos_tilt_q;
      tx_f_q  <= tx_e_q;
      in_f_q  <= in_e_q;
      ry_g_q  <= ry_s[RW-1:0];
      rz_g_q  <= rz_s[RW-1:0];
      tx_g_q  <= tx_f_q;
      in_g_q  <= in_f_q;
    end
  end

  stcm_isqrt #(
    .OUT_W  (OW),
    .SIDE_W ($bits(sq1_side_t))
  ) u_depth_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_b_q),
    .rad_i   (rad1_c),
    .side_i  (sq1_in),
    .valid_o (sq1_valid),
    .root_o  (pz),
    .side_o  (sq1_out)
  );

  assign ang1_in.on_disc = in_g_q;
  assign ang1_in.ry      = ry_g_q;

  stcm_cordic #(
    .IN_W   (RW),
    .SIDE_W ($bits(ang1_side_t))
  ) u_lon_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_g_q),
    .y_i     (tx_g_q),
    .x_i     (rz_g_q),
    .side_i  (ang1_in),
    .valid_o (ang1_valid),
    .ang_o   (theta),
    .side_o  (ang1_out)
  );

  // Longitude offset, clamped latitude sine and latitude root radicand
  always_comb begin
    u_c = AW'(stcm_pkg::ANG_HALF) + theta;
    if (u_c < 0) begin
      u_c = u_c + AW'(stcm_pkg::ANG_ONE);
    end
    neg_ry = -ang1_out.ry;
    if (neg_ry > big_r) begin
      s_c = big_r;
    end else if (neg_ry < -big_r) begin
      s_c = -big_r;
    end else begin
      s_c = neg_ry;
    end
    rad2_c = {r_sq, {(2*FRAC_BITS){1'b0}}} - sq_i_q[2*OW-1:0];
    sq2_in.on_disc = in_i_q;
    sq2_in.u       = u_i_q;
    sq2_in.s       = s_i_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_h_q  <= u_c;
      s_h_q  <= s_c[OW:0];
      in_h_q <= ang1_out.on_disc;
      sq_i_q <= s_h_q * s_h_q;
      u_i_q  <= u_h_q;
      s_i_q  <= s_h_q;
      in_i_q <= in_h_q;
    end
  end

  stcm_isqrt #(
    .OUT_W  (OW),
    .SIDE_W ($bits(sq2_side_t))
  ) u_lat_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_i_q),
    .rad_i   (rad2_c),
    .side_i  (sq2_in),
    .valid_o (sq2_valid),
    .root_o  (qv),
    .side_o  (sq2_out)
  );

  assign ang2_in.on_disc = sq2_out.on_disc;
  assign ang2_in.u       = sq2_out.u;

  stcm_cordic #(
    .IN_W   (RW),
    .SIDE_W ($bits(ang2_side_t))
  ) u_lat_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq2_valid),
    .y_i     (RW'($signed({1'b0, qv}))),
    .x_i     (RW'(sq2_out.s)),
    .side_i  (ang2_in),
    .valid_o (ang2_valid),
    .ang_o   (phi),
    .side_o  (ang2_out)
  );

  // Round to Q0.16, scale by texture size, clamp, and zero off-disc items
  always_comb begin
    ur_c = ang2_out.u + AW'(stcm_pkg::Q16_ROUND);
    vr_c = (phi <<< 1) + AW'(stcm_pkg::Q16_ROUND);
    mw_c = (tex_w_q == '0) ? '0 : tex_w_q - 1'b1;
    mh_c = (tex_h_q == '0) ? '0 : tex_h_q - 1'b1;
    tx_full = pu_l_q[PUW-1:stcm_pkg::Q16_FRAC];
    ty_full = pv_l_q[PUW-1:stcm_pkg::Q16_FRAC];
    res_d.inside_res = in_l_q;
    res_d.tex_x = (tx_full > (SW+1)'({C{1'b1}})) ? {C{1'b1}} : tx_full[C-1:0];
    res_d.tex_y = (ty_full > (SW+1)'({C{1'b1}})) ? {C{1'b1}} : ty_full[C-1:0];
    if (!in_l_q) begin
      res_d.tex_x = '0;
      res_d.tex_y = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qu_k_q <= ur_c[stcm_pkg::Q16_SHIFT +: QW];
      qv_k_q <= QW'(stcm_pkg::Q16_ONE) - vr_c[stcm_pkg::Q16_SHIFT +: QW];
      in_k_q <= ang2_out.on_disc;
      pu_l_q <= qu_k_q * mw_c;
      pv_l_q <= qv_k_q * mh_c;
      in_l_q <= in_k_q;
      res_q  <= res_d;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = res_q;

  // Off-disc items carry zero coordinates
  `ASSERT_IMPLY(a_outside_zero, clk_i, rst_ni, valid_o && !res_q.inside_res, ~|res_q[2*C-1:0])
  // A stalled output item is still there next cycle
  `ASSERT_NEXT(a_stall_keeps_out, clk_i, rst_ni, stall_o, valid_o)
  // The stage behind the output freezes along with it
  `ASSERT_NEXT(a_stall_keeps_last, clk_i, rst_ni, stall_o && v_l_q, v_l_q)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int HALF_PERIOD = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 130;
  localparam int MAX_REPORTS = 10;
  localparam int CB = stcm_pkg::COORD_BITS;
  localparam int FB = stcm_pkg::FRAC_BITS_DEF;
  localparam int IDX_W = stcm_pkg::CFG_IDX_W;
  localparam int DAT_W = stcm_pkg::CFG_DATA_W;
  localparam logic [IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam longint COORD_MAX = (longint'(1) << CB) - 1;

  logic clk;
  logic rst_ni;
  logic valid_i;
  logic stall_o;
  stcm_pkg::pix_t pix_i;
  logic valid_o;
  logic stall_i;
  stcm_pkg::tex_t res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i;
  logic [DAT_W-1:0] cfg_data_i;

  sphere_texture_coordinate_mapper_core DUT (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .pix_i(pix_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .res_o(res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the mapper registers
  logic [stcm_pkg::RADIUS_W-1:0] radius_q;
  longint cos_spin_q, sin_spin_q, cos_tilt_q, sin_tilt_q;
  logic [stcm_pkg::TSIZE_W-1:0] tex_w_q, tex_h_q;

  stcm_pkg::tex_t texel_q[$];
  int mismatch_cnt;
  bit send_idle;
  bit recv_idle;
  int hold_cycles;
  int quiet_cycles;

  // atan(2^-i) in 2^-24 turn
  longint arc_step[stcm_pkg::ANG_STEPS] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Vectoring rotation; angle in 2^-24 turn within half a turn either way
  function automatic longint angle_of(longint yv, longint xv);
    longint x, y, z, dx, dy;
    x = (xv < 0) ? -xv : xv;
    y = (yv < 0) ? -yv : yv;
    z = 0;
    for (int i = 0; i < stcm_pkg::ANG_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arc_step[i];
      end else if (y < 0) begin
        x -= dx; y += dy; z -= arc_step[i];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(stcm_pkg::ANG_QUARTER)) z = longint'(stcm_pkg::ANG_QUARTER);
    if (xv < 0) z = longint'(stcm_pkg::ANG_HALF) - z;
    if (yv < 0) z = -z;
    return z;
  endfunction

  function automatic longint to_unit16(longint a24);
    return (a24 + longint'(stcm_pkg::Q16_ROUND)) >>> stcm_pkg::Q16_SHIFT;
  endfunction

  function automatic logic [CB-1:0] texel_index(longint q16, longint size);
    longint span, t;
    span = (size != 0) ? size - 1 : 0;
    t = (q16 * span) >>> stcm_pkg::Q16_FRAC;
    if (t > COORD_MAX) t = COORD_MAX;
    return CB'(t);
  endfunction

  // Map one screen pixel to the texel it samples
  function automatic stcm_pkg::tex_t map_pixel(stcm_pkg::pix_t p);
    longint r, lx, ly, d2, px, py, pz, tx, tz, ry, rz, s, big_r, u24, v24, one;
    longint unsigned q;
    stcm_pkg::tex_t res;
    res = '0;
    one = longint'(1) << FB;
    r = longint'(radius_q);
    lx = longint'(p.pix_x) - r;
    ly = longint'(p.pix_y) - r;
    d2 = lx * lx + ly * ly;
    if (d2 > r * r) return res;
    px = lx * one;
    py = ly * one;
    pz = longint'(int_sqrt((r * r - d2) << (2 * FB)));
    tx = (px * cos_spin_q - pz * sin_spin_q) >>> stcm_pkg::TRIG_SHIFT;
    tz = (px * sin_spin_q + pz * cos_spin_q) >>> stcm_pkg::TRIG_SHIFT;
    ry = (py * cos_tilt_q - tz * sin_tilt_q) >>> stcm_pkg::TRIG_SHIFT;
    rz = (py * sin_tilt_q + tz * cos_tilt_q) >>> stcm_pkg::TRIG_SHIFT;
    u24 = longint'(stcm_pkg::ANG_HALF) + angle_of(tx, rz);
    if (u24 < 0) u24 += longint'(stcm_pkg::ANG_ONE);
    big_r = r * one;
    s = -ry;
    if (s > big_r) s = big_r;
    if (s < -big_r) s = -big_r;
    q = int_sqrt(big_r * big_r - s * s);
    v24 = 2 * angle_of(longint'(q), s);
    res.inside_res = 1'b1;
    res.tex_x = texel_index(to_unit16(u24), longint'(tex_w_q));
    res.tex_y = texel_index(longint'(stcm_pkg::Q16_ONE) - to_unit16(v24),
                            longint'(tex_h_q));
    return res;
  endfunction

  function automatic void update_shadow(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] d);
    case (idx)
      stcm_pkg::CFG_RADIUS:   radius_q = d[stcm_pkg::RADIUS_W-1:0];
      stcm_pkg::CFG_COS_SPIN: cos_spin_q = longint'($signed(d));
      stcm_pkg::CFG_SIN_SPIN: sin_spin_q = longint'($signed(d));
      stcm_pkg::CFG_COS_TILT: cos_tilt_q = longint'($signed(d));
      stcm_pkg::CFG_SIN_TILT: sin_tilt_q = longint'($signed(d));
      stcm_pkg::CFG_TEX_W:    tex_w_q = d[stcm_pkg::TSIZE_W-1:0];
      stcm_pkg::CFG_TEX_H:    tex_h_q = d[stcm_pkg::TSIZE_W-1:0];
      default: ;
    endcase
  endfunction

  // Receiver: long hold first, then random stall bursts
  initial begin
    int burst;
    burst = 0;
    stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        stall_i = 1'b1;
        hold_cycles--;
      end else if (burst > 0) begin
        stall_i = 1'b1;
        burst--;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        stall_i = 1'b1;
        burst = int'($urandom_range(0, 3));
      end else begin
        stall_i = 1'b0;
      end
    end
  end

  // Compare each result with the oldest pending texel
  always @(posedge clk) begin
    stcm_pkg::tex_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (texel_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: inside=%0d x=%0d y=%0d",
                   res_o.inside_res, res_o.tex_x, res_o.tex_y);
      end else begin
        want = texel_q.pop_front();
        if (res_o.inside_res !== want.inside_res || res_o.tex_x !== want.tex_x ||
            res_o.tex_y !== want.tex_y) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"mismatch: expected inside=%0d x=%0d y=%0d,",
                      " got inside=%0d x=%0d y=%0d"},
                     want.inside_res, want.tex_x, want.tex_y,
                     res_o.inside_res, res_o.tex_x, res_o.tex_y);
        end
      end
    end
  end

  // Stop the run when no handshake happens for too long
  always @(posedge clk) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_pixel(input stcm_pkg::pix_t p);
    @(negedge clk);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    valid_i = 1'b1;
    pix_i = p;
    do @(posedge clk); while (stall_o);
    texel_q.push_back(map_pixel(p));
  endtask

  task automatic send_xy(input int x, input int y);
    stcm_pkg::pix_t p;
    p.pix_x = CB'(x);
    p.pix_y = CB'(y);
    send_pixel(p);
  endtask

  // Drop valid and hold until every pending texel is back
  task automatic drain;
    @(negedge clk);
    valid_i = 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = DAT_W'(value);
    do @(posedge clk); while (!cfg_ready_o);
    update_shadow(idx, DAT_W'(value));
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_angles(input int spin_deg, input int tilt_deg);
    real a, b;
    a = spin_deg * 3.14159265358979 / 180.0;
    b = tilt_deg * 3.14159265358979 / 180.0;
    write_reg(stcm_pkg::CFG_COS_SPIN, int'($cos(a) * stcm_pkg::TRIG_ONE));
    write_reg(stcm_pkg::CFG_SIN_SPIN, int'($sin(a) * stcm_pkg::TRIG_ONE));
    write_reg(stcm_pkg::CFG_COS_TILT, int'($cos(b) * stcm_pkg::TRIG_ONE));
    write_reg(stcm_pkg::CFG_SIN_TILT, int'($sin(b) * stcm_pkg::TRIG_ONE));
  endtask

  // Pixels mostly inside the disc box, some over the full field
  task automatic send_random(input int count);
    int span;
    stcm_pkg::pix_t p;
    span = 2 * int'(radius_q);
    if (span > int'(COORD_MAX)) span = int'(COORD_MAX);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        p.pix_x = CB'($urandom);
        p.pix_y = CB'($urandom);
      end else begin
        p.pix_x = CB'($urandom_range(0, span));
        p.pix_y = CB'($urandom_range(0, span));
      end
      send_pixel(p);
    end
  endtask

  // Disc edges, center and far corners at reset settings
  task automatic test_reset_values;
    send_xy(0, 0);
    send_xy(128, 128);
    send_xy(0, 128);
    send_xy(256, 128);
    send_xy(128, 0);
    send_xy(128, 256);
    send_xy(1023, 1023);
    send_xy(1023, 0);
    send_xy(37, 200);
    drain();
  endtask

  // Back seam, zero radius, zero and oversized textures, raw register bits
  task automatic test_special_cases;
    write_reg(stcm_pkg::CFG_COS_SPIN, -stcm_pkg::TRIG_ONE);
    write_reg(stcm_pkg::CFG_SIN_SPIN, 0);
    send_xy(128, 128);
    send_xy(128, 60);
    send_xy(128, 200);
    drain();
    write_reg(stcm_pkg::CFG_RADIUS, 0);
    write_reg(stcm_pkg::CFG_TEX_W, 0);
    write_reg(stcm_pkg::CFG_TEX_H, 0);
    send_xy(0, 0);
    send_xy(1, 0);
    send_xy(0, 1);
    drain();
    write_reg(stcm_pkg::CFG_RADIUS, 511);
    write_reg(stcm_pkg::CFG_TEX_W, 2047);
    write_reg(stcm_pkg::CFG_TEX_H, 2047);
    send_xy(511, 511);
    send_xy(0, 511);
    send_xy(1022, 511);
    send_xy(511, 0);
    drain();
    write_reg(stcm_pkg::CFG_COS_SPIN, 32767);
    write_reg(stcm_pkg::CFG_SIN_SPIN, -32768);
    write_reg(stcm_pkg::CFG_COS_TILT, -32768);
    write_reg(stcm_pkg::CFG_SIN_TILT, 32767);
    write_reg(CFG_UNUSED_IDX, 16'hffff);
    write_reg(stcm_pkg::CFG_RADIUS, 16'hfe01);
    send_xy(1, 1);
    send_xy(300, 700);
    send_xy(511, 511);
    drain();
  endtask

  // Sweep radius, angles and texture sizes through random settings
  task automatic test_random_settings(input int phases, input int per_phase);
    int rad;
    for (int k = 0; k < phases; k++) begin
      case (k % 4)
        0: rad = 1;
        1: rad = 511;
        default: rad = int'($urandom_range(1, 511));
      endcase
      write_reg(stcm_pkg::CFG_RADIUS, rad);
      if (k % 3 == 2) begin
        write_reg(stcm_pkg::CFG_COS_SPIN, int'($urandom));
        write_reg(stcm_pkg::CFG_SIN_SPIN, int'($urandom));
        write_reg(stcm_pkg::CFG_COS_TILT, int'($urandom));
        write_reg(stcm_pkg::CFG_SIN_TILT, int'($urandom));
      end else begin
        set_angles(int'($urandom_range(0, 359)), int'($urandom_range(0, 359)));
      end
      write_reg(stcm_pkg::CFG_TEX_W, (k % 2) ? 1024 : int'($urandom_range(2, 1024)));
      write_reg(stcm_pkg::CFG_TEX_H, (k % 2) ? 2 : int'($urandom_range(2, 1024)));
      send_random(per_phase);
      drain();
    end
  endtask

  // Hold the output long enough that the pipeline fills and stalls input
  task automatic test_backpressure;
    hold_cycles = 300;
    send_random(250);
    drain();
  endtask

  // Full rate with no idling on either side
  task automatic test_full_rate;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_angles(45, 30);
    write_reg(stcm_pkg::CFG_RADIUS, 200);
    write_reg(stcm_pkg::CFG_TEX_W, 512);
    write_reg(stcm_pkg::CFG_TEX_H, 256);
    send_random(120);
    @(negedge clk);
    valid_i = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    valid_i = 1'b0;
    pix_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = stcm_pkg::CFG_RADIUS;
    cfg_data_i = '0;
    mismatch_cnt = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    radius_q = stcm_pkg::RADIUS_W'(stcm_pkg::RADIUS_RST);
    cos_spin_q = longint'(stcm_pkg::TRIG_ONE);
    sin_spin_q = 0;
    cos_tilt_q = longint'(stcm_pkg::TRIG_ONE);
    sin_tilt_q = 0;
    tex_w_q = stcm_pkg::TSIZE_W'(stcm_pkg::TSIZE_RST);
    tex_h_q = stcm_pkg::TSIZE_W'(stcm_pkg::TSIZE_RST);
    repeat (3) @(negedge clk);
    rst_ni = 1'b1;

    test_reset_values();
    test_special_cases();
    test_random_settings(7, 120);
    test_backpressure();
    test_full_rate();

    while (texel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && texel_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/stcm_pkg.sv
rtl/stcm_isqrt.sv
rtl/stcm_cordic.sv
rtl/sphere_texture_coordinate_mapper_core.sv
tb/tb.sv
